/* design/assert_macros.svh */
// Assertion macros shared by the access rights table modules.
// Each macro expects a clock and a synchronous active-high reset to be passed in.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is high.
`define AST_PROP(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define AST_NEVER(lbl, clk_s, rst_s, cond, msg) \
  `AST_PROP(lbl, clk_s, rst_s, !(cond), msg)

`endif

/* design/art_pkg.sv */
// Shared types for the access rights table: state codes, function codes and
// the command and status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package art_pkg;

  // Item function codes
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the incoming item, restart the scan
    logic scan;      // issue the next entry read and advance the compare stage
    logic wr_match;  // overwrite rights of the matching entry
    logic wr_new;    // insert identifier and rights into the free slot
    logic finish;    // capture the result fields
    logic full;      // result status: table full
    logic grant;     // result granted
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query;  // captured item is a query
    logic match;     // compared entry is valid and holds the identifier
    logic last;      // compared entry is the last slot
    logic overlap;   // compared entry rights share a bit with the mask
    logic has_free;  // an empty slot has been seen up to and including this entry
  } stat_t;

endpackage

/* design/art_ctrl.sv */
// Controller state machine of the access rights table.
// Depends on art_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module art_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  art_pkg::stat_t stat,
  output art_pkg::cmd_t  cmd
);

  art_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= art_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      art_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = art_pkg::ST_SCAN;
        end
      end
      art_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        priority if (stat.match) begin
          cmd.finish   = 1'b1;
          cmd.wr_match = !stat.is_query;
          cmd.grant    = stat.is_query && stat.overlap;
          state_next   = art_pkg::ST_RESP;
        end else if (stat.last) begin
          cmd.finish = 1'b1;
          cmd.wr_new = !stat.is_query && stat.has_free;
          cmd.full   = !stat.is_query && !stat.has_free;
          state_next = art_pkg::ST_RESP;
        end else begin
          // advance to the next slot
          state_next = art_pkg::ST_SCAN;
        end
      end
      art_pkg::ST_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = art_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = art_pkg::ST_IDLE;
      end
    endcase
  end

  `AST_PROP(a_finish_cause, clk, rst, cmd.finish |-> (stat.match || stat.last),
            "finish without a match or end of scan")
  `AST_PROP(a_resp_after_finish, clk, rst, cmd.finish |=> out_valid,
            "result not presented after finish")
  `AST_NEVER(a_full_on_query, clk, rst, cmd.full && stat.is_query,
             "table full reported for a query")

endmodule

/* design/art_dp.sv */
// Datapath of the access rights table: item registers, key and rights memories,
// valid bits, scan counter, compare stage and result registers. Depends on art_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module art_dp #(
  parameter int ENTRIES = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           func,
  input  logic [15:0]    ident,
  input  logic [7:0]     mode,
  input  logic [7:0]     auth_mask,
  input  art_pkg::cmd_t  cmd,
  output art_pkg::stat_t stat,
  output logic           status,
  output logic           granted
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  // Captured item
  logic        func_r;
  logic [15:0] ident_r;
  logic [7:0]  mode_r;
  logic [7:0]  mask_r;

  // Table storage
  logic [15:0]        mem_key    [ENTRIES];
  logic [7:0]         mem_rights [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;

  // Scan pipeline
  logic [CW-1:0] rd_addr;
  logic          rd_issue;
  logic [15:0]   key_q;
  logic [7:0]    rights_q;
  logic          vld_q;
  logic          cmp_vld;
  logic [IW-1:0] cmp_idx;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] new_idx;
  logic [IW-1:0] wr_idx;

  assign rd_issue = cmd.scan && (rd_addr < CW'(ENTRIES));
  assign new_idx  = free_found ? free_idx : cmp_idx;
  assign wr_idx   = cmd.wr_new ? new_idx : cmp_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= func;
      ident_r <= ident;
      mode_r  <= mode;
      mask_r  <= auth_mask;
    end
  end

  // Memory read, registered
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      key_q    <= mem_key[rd_addr[IW-1:0]];
      rights_q <= mem_rights[rd_addr[IW-1:0]];
      vld_q    <= entry_valid[rd_addr[IW-1:0]];
      cmp_idx  <= rd_addr[IW-1:0];
    end
  end

  // Memory write
  always_ff @(posedge clk) begin
    if (cmd.wr_new) begin
      mem_key[wr_idx] <= ident_r;
    end
    if (cmd.wr_new || cmd.wr_match) begin
      mem_rights[wr_idx] <= mode_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.wr_new) begin
      entry_valid[new_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr    <= '0;
      cmp_vld    <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      rd_addr    <= '0;
      cmp_vld    <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan) begin
      cmp_vld <= rd_issue;
      if (rd_issue) begin
        rd_addr <= rd_addr + CW'(1);
      end
      if (cmp_vld && !vld_q && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && cmp_vld && !vld_q && !free_found) begin
      free_idx <= cmp_idx;
    end
  end

  always_comb begin
    stat.is_query = (func_r == art_pkg::FUNC_QUERY);
    stat.match    = cmp_vld && vld_q && (key_q == ident_r);
    stat.last     = cmp_vld && (cmp_idx == IW'(ENTRIES - 1));
    stat.overlap  = (rights_q & mask_r) != 8'd0;
    stat.has_free = free_found || (cmp_vld && !vld_q);
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status  <= cmd.full;
      granted <= cmd.grant;
    end
  end

  `AST_PROP(a_insert_needs_free, clk, rst, cmd.wr_new |-> stat.has_free,
            "insert without an empty slot")
  `AST_PROP(a_insert_grows, clk, rst,
            cmd.wr_new |=> $countones(entry_valid) == $past($countones(entry_valid)) + 1,
            "insert did not occupy a new slot")
  `AST_NEVER(a_one_write, clk, rst, cmd.wr_new && cmd.wr_match,
             "insert and overwrite in the same cycle")

endmodule

/* design/access_rights_table.sv */
// Top level of the access rights table: joins the controller and the datapath.
// Depends on art_pkg, art_ctrl and art_dp.
`timescale 1ns / 1ps
//
// Associative table of identifier to rights entries, ENTRIES slots.
// Input channel (in_valid/in_ready) carries one item per transaction:
//   func = 0 updates the rights of ident to mode, inserting ident into the
//   lowest empty slot if no valid entry holds it; func = 1 queries whether
//   the entry for ident shares any bit with auth_mask.
// Output channel (out_valid/out_ready) returns one transaction per item:
//   status = 1 when an update found the table full (nothing stored),
//   granted = 1 when a query match overlaps auth_mask; the unused field is 0.
// Scan: the table is scanned one slot per cycle through a registered
// memory read, and the scan stops early when the identifier is found.
// Throughput: one item in flight; in_ready is high only while idle, so the
// next item is taken the cycle after the result transaction completes.
// Stall: the result holds on the output until out_ready; no new item is
// accepted meanwhile.
// Reset: rst clears the state machine and all valid marks at once; the
// table is empty and ready in the first cycle after reset.
//

module access_rights_table #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [15:0] ident,
  input  logic [7:0]  mode,
  input  logic [7:0]  auth_mask,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic        granted
);

  // Command and status between the two halves
  art_pkg::cmd_t  cmd;
  art_pkg::stat_t stat;

  // Sequence the scan and the handshakes
  art_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the table, compare one slot per cycle, hold the result
  art_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .func      (func),
    .ident     (ident),
    .mode      (mode),
    .auth_mask (auth_mask),
    .cmd       (cmd),
    .stat      (stat),
    .status    (status),
    .granted   (granted)
  );

endmodule

/* tb/sv/access_rights_table_tb.sv */
// Self-checking testbench for access_rights_table: directed and random updates and queries
// with random idling on both channels, checked against an in-bench model of the table.
// Depends on art_pkg and the access_rights_table RTL.
`timescale 1ns / 1ps

module access_rights_table_tb;

  localparam int TABLE_SLOTS = 16;
  localparam int ITEM_COUNT  = 1300;
  localparam int POOL_SIZE   = 16;
  // Receiver freezes once this many transactions went in; HOLD_CYCLES sets its length.
  localparam int HOLD_AT     = 500;
  localparam int HOLD_CYCLES = 300;
  // Extra cycles after the last result: one full scan plus margin.
  localparam int DRAIN_CYCLES = TABLE_SLOTS + 8;

  typedef struct {
    logic        func;
    logic [15:0] ident;
    logic [7:0]  mode;
    logic [7:0]  auth_mask;
    bit          wait_drain;  // hold this item back until every result is in
  } rights_req_t;

  typedef struct {
    logic status;
    logic granted;
  } rights_resp_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        func;
  logic [15:0] ident;
  logic [7:0]  mode;
  logic [7:0]  auth_mask;
  logic        out_valid;
  logic        out_ready;
  logic        status;
  logic        granted;

  rights_req_t  pending_reqs[$];
  rights_resp_t expected_resps[$];

  // Shadow of the table contents, updated at each input transaction.
  bit          shadow_valid [TABLE_SLOTS];
  logic [15:0] shadow_key   [TABLE_SLOTS];
  logic [7:0]  shadow_rights[TABLE_SLOTS];

  logic [15:0] ident_pool[POOL_SIZE];

  int  items_in;
  int  results_out;
  int  mismatches;
  int  n_stored;
  int  n_full;
  int  n_granted;
  int  n_denied;
  int  send_gap;
  int  recv_gap;
  int  hold_left;
  bit  hold_done;
  bit  in_taken;

  access_rights_table #(
    .ENTRIES(TABLE_SLOTS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .ident     (ident),
    .mode      (mode),
    .auth_mask (auth_mask),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .granted   (granted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idling stays off in every fourth block of 120 transactions and in the tail.
  function automatic bit idle_allowed(int n);
    return (n < ITEM_COUNT - 150) && ((n / 120) % 4 != 3);
  endfunction

  // Apply one item to the shadow table and return the result it must produce.
  function automatic rights_resp_t apply_rights_item(logic f, logic [15:0] id,
                                                     logic [7:0] md, logic [7:0] msk);
    rights_resp_t r;
    int free_slot;
    bit hit;
    r.status  = 1'b0;
    r.granted = 1'b0;
    free_slot = -1;
    hit = 1'b0;
    if (f == art_pkg::FUNC_UPDATE) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (shadow_valid[i]) begin
          if (!hit && shadow_key[i] == id) begin
            shadow_rights[i] = md;
            hit = 1'b1;
          end
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (!hit && free_slot < 0) begin
        r.status = 1'b1;
      end else if (!hit) begin
        shadow_valid[free_slot]  = 1'b1;
        shadow_key[free_slot]    = id;
        shadow_rights[free_slot] = md;
      end
    end else begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (shadow_valid[i] && shadow_key[i] == id && (shadow_rights[i] & msk) != 8'h00)
          r.granted = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void push_item(logic f, logic [15:0] id, logic [7:0] md,
                                    logic [7:0] msk, bit drain);
    rights_req_t q;
    q.func       = f;
    q.ident      = id;
    q.mode       = md;
    q.auth_mask  = msk;
    q.wait_drain = drain;
    pending_reqs.push_back(q);
  endfunction

  // Input side: offer the next item at the falling edge; valid never waits for ready
  // and stays up with a steady payload until the transaction completes.
  always @(negedge clk) begin : feed_items
    rights_req_t nxt;
    logic offer;
    if (!rst) begin
      offer = in_valid;
      if (in_taken) begin
        in_taken = 1'b0;
        offer = 1'b0;
        if (idle_allowed(items_in) && $urandom_range(0, 3) == 0)
          send_gap = $urandom_range(1, 18);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].wait_drain && expected_resps.size() != 0)) begin
          nxt = pending_reqs.pop_front();
          func      <= nxt.func;
          ident     <= nxt.ident;
          mode      <= nxt.mode;
          auth_mask <= nxt.auth_mask;
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  // Output side: random ready bursts, plus one long freeze that backs the block up.
  always @(negedge clk) begin : drain_results
    logic rdy;
    if (!rst) begin
      rdy = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && items_in >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rdy = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rdy = 1'b0;
      end else if (idle_allowed(results_out) && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(1, 18) - 1;
        rdy = 1'b0;
      end
      out_ready <= rdy;
    end
  end

  // Sample both channels at the rising edge. Check the result before predicting the
  // next item, so a same-edge pair would still line up in order.
  always @(posedge clk) begin : watch_channels
    rights_resp_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_resps.size() == 0) begin
          $error("result transaction %0d arrived with no item outstanding", results_out);
          mismatches++;
        end else begin
          want = expected_resps.pop_front();
          if (status !== want.status) begin
            $error("status mismatch on result %0d: expected %0b, got %0b",
                   results_out, want.status, status);
            mismatches++;
          end
          if (granted !== want.granted) begin
            $error("granted mismatch on result %0d: expected %0b, got %0b",
                   results_out, want.granted, granted);
            mismatches++;
          end
        end
        results_out++;
      end
      if (in_valid && in_ready) begin
        want = apply_rights_item(func, ident, mode, auth_mask);
        expected_resps.push_back(want);
        if (func == art_pkg::FUNC_UPDATE) begin
          if (want.status) n_full++;
          else n_stored++;
        end else begin
          if (want.granted) n_granted++;
          else n_denied++;
        end
        items_in++;
        in_taken = 1'b1;
      end
    end
  end

  initial begin : run_test
    bit dup;
    int n_directed;
    logic [15:0] id;
    logic [7:0]  md;
    logic [7:0]  msk;
    logic        f;
    rst = 1'b1;
    in_valid = 1'b0;
    func = art_pkg::FUNC_UPDATE;
    ident = '0;
    mode = '0;
    auth_mask = '0;
    out_ready = 1'b0;
    items_in = 0;
    results_out = 0;
    mismatches = 0;
    n_stored = 0;
    n_full = 0;
    n_granted = 0;
    n_denied = 0;
    send_gap = 0;
    recv_gap = 0;
    hold_left = 0;
    hold_done = 1'b0;
    in_taken = 1'b0;
    for (int i = 0; i < TABLE_SLOTS; i++) shadow_valid[i] = 1'b0;

    // Identifiers that the random part keeps coming back to; the two extremes
    // are already in the table after the directed part.
    ident_pool[0] = 16'h0000;
    ident_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) begin
      do begin
        id  = 16'($urandom_range(0, 16'hFFFF));
        dup = 1'b0;
        for (int j = 0; j < i; j++) if (ident_pool[j] == id) dup = 1'b1;
      end while (dup);
      ident_pool[i] = id;
    end

    // Directed: empty table, zero mode, zero mask, overwrite, absent identifier.
    push_item(art_pkg::FUNC_QUERY,  16'h0000, 8'h00, 8'hFF, 1'b0);
    push_item(art_pkg::FUNC_UPDATE, 16'h0000, 8'h00, 8'hFF, 1'b0);
    push_item(art_pkg::FUNC_QUERY,  16'h0000, 8'hFF, 8'hFF, 1'b0);
    push_item(art_pkg::FUNC_UPDATE, 16'hFFFF, 8'hFF, 8'h00, 1'b0);
    push_item(art_pkg::FUNC_QUERY,  16'hFFFF, 8'h00, 8'h00, 1'b0);
    push_item(art_pkg::FUNC_QUERY,  16'hFFFF, 8'h00, 8'h01, 1'b0);
    push_item(art_pkg::FUNC_QUERY,  16'hFFFF, 8'h00, 8'h80, 1'b0);
    push_item(art_pkg::FUNC_UPDATE, 16'h0000, 8'h80, 8'h00, 1'b0);
    push_item(art_pkg::FUNC_QUERY,  16'h0000, 8'h00, 8'h80, 1'b0);
    push_item(art_pkg::FUNC_QUERY,  16'h0000, 8'h00, 8'h7F, 1'b0);
    push_item(art_pkg::FUNC_QUERY,  16'h1234, 8'h00, 8'hFF, 1'b0);
    push_item(art_pkg::FUNC_UPDATE, 16'hFFFF, 8'h5A, 8'hA5, 1'b0);
    push_item(art_pkg::FUNC_QUERY,  16'hFFFF, 8'h00, 8'hA5, 1'b0);
    n_directed = pending_reqs.size();

    // Random: mostly pool identifiers so that overwrites and grants are common;
    // strangers fill the free slots and then run into a full table.
    for (int k = n_directed; k < ITEM_COUNT; k++) begin
      f = $urandom_range(0, 1) ? art_pkg::FUNC_QUERY : art_pkg::FUNC_UPDATE;
      if ($urandom_range(0, 4) == 0) id = 16'($urandom_range(0, 16'hFFFF));
      else id = ident_pool[$urandom_range(0, POOL_SIZE - 1)];
      case ($urandom_range(0, 9))
        0: md = 8'h00;
        1: md = 8'hFF;
        default: md = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 9))
        0: msk = 8'h00;
        1: msk = 8'hFF;
        2, 3: msk = 8'h01 << $urandom_range(0, 7);
        default: msk = 8'($urandom_range(0, 255));
      endcase
      push_item(f, id, md, msk, (k == n_directed) || (k == 800));
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (items_in < ITEM_COUNT) @(posedge clk);
    while (expected_resps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items: %0d updates stored, %0d refused on a full table,",
             items_in, n_stored, n_full);
    $display("%0d queries granted and %0d denied; %0d results checked, %0d mismatches.",
             n_granted, n_denied, results_out, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
